@@ rtl/mi3_pkg.sv @@
package mi3_pkg;

    // Default fraction width of the fixed-point entries
    localparam int FRAC_BITS_DEF = 16;

    // Fixed datapath widths
    localparam int ENT_W   = 32;   // one matrix entry
    localparam int PROD_W  = 64;   // entry times entry
    localparam int COF_W   = 65;   // 2x2 cofactor, signed
    localparam int PH_W    = 65;   // entry times a 33-bit cofactor slice
    localparam int DET_W   = 97;   // determinant, signed
    localparam int DM_W    = 96;   // determinant magnitude
    localparam int CMAG_W  = 64;   // cofactor magnitude
    localparam int QUO_W   = 32;   // quotient bits kept
    localparam int N_ENT   = 9;

    localparam logic [QUO_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef logic signed [ENT_W-1:0] ent_t;

    typedef struct packed {
        ent_t a00;
        ent_t a01;
        ent_t a02;
        ent_t a10;
        ent_t a11;
        ent_t a12;
        ent_t a20;
        ent_t a21;
        ent_t a22;
    } mat_t;

    typedef struct packed {
        ent_t r00;
        ent_t r01;
        ent_t r02;
        ent_t r10;
        ent_t r11;
        ent_t r12;
        ent_t r20;
        ent_t r21;
        ent_t r22;
        logic singular;
        logic saturated;
    } inv_t;

    // One lane of the restoring divider between two steps
    typedef struct packed {
        logic [DM_W-1:0]  rem;
        logic [QUO_W-1:0] lo;    // numerator bits still to shift in
        logic [QUO_W-1:0] q;
        logic             neg;
        logic             ovf;   // quotient known to be at least 2^32
    } div_t;

endpackage

@@ rtl/mi3_stream_if.sv @@
interface mi3_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/matrix_inverse_3x3_unit.sv @@
// 3x3 matrix inverse by the adjugate rule, signed fixed point.
// Channel mat (sink) takes one matrix per transaction, nine entries a00..a22
// with FRAC_BITS fraction bits. Channel inv (source) gives one transaction
// per matrix: r00..r22 = adjugate / determinant, truncated toward zero and
// clamped to 32 bits (saturated set when any entry clamps). A matrix whose
// determinant is exactly zero comes back unchanged with singular set.
// Each matrix passes through 40 register stages: 6 stages of multiply and
// sum for cofactors and determinant, one overflow check, 32 restoring divide
// steps (one quotient bit per stage, nine lanes) and the output register.
// The pipe takes one matrix per cycle while inv does not stall.
// All stages move together on one enable; when inv stalls with a result
// waiting, the whole pipe holds and mat.ready drops, and nothing is lost
// or repeated. mat.ready is high while inv.valid is low or inv.ready is high.
// Reset clears all valid bits; no result is pending after reset.
module matrix_inverse_3x3_unit #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    mi3_stream_if.sink   mat,
    mi3_stream_if.source inv
);
    import mi3_pkg::*;

    localparam int NUM_W     = CMAG_W + 2 * FRAC_BITS;
    localparam int DIV_STEPS = QUO_W;

    // pipeline enable
    logic en;
    assign en        = !inv.valid || inv.ready;
    assign mat.ready = en;

    // valid bits
    logic [5:0]           vs_reg;
    logic [DIV_STEPS:0]   vd_reg;
    logic                 out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg        <= '0;
            vd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vs_reg        <= {vs_reg[4:0], mat.valid};
            vd_reg        <= {vd_reg[DIV_STEPS-1:0], vs_reg[5]};
            out_valid_reg <= vd_reg[DIV_STEPS];
        end
    end

    // input entries as an array
    ent_t m_in [N_ENT];
    assign m_in[0] = mat.data.a00;
    assign m_in[1] = mat.data.a01;
    assign m_in[2] = mat.data.a02;
    assign m_in[3] = mat.data.a10;
    assign m_in[4] = mat.data.a11;
    assign m_in[5] = mat.data.a12;
    assign m_in[6] = mat.data.a20;
    assign m_in[7] = mat.data.a21;
    assign m_in[8] = mat.data.a22;

    // stage 1: the two products of each cofactor
    logic signed [PROD_W-1:0] pa_next [N_ENT];
    logic signed [PROD_W-1:0] pb_next [N_ENT];
    logic signed [PROD_W-1:0] pa1_reg [N_ENT];
    logic signed [PROD_W-1:0] pb1_reg [N_ENT];
    mat_t                     m1_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int R0  = (r == 0) ? 1 : 0;
            localparam int R1  = (r == 2) ? 1 : 2;
            localparam int C0  = (c == 0) ? 1 : 0;
            localparam int C1  = (c == 2) ? 1 : 2;
            localparam int ODD = (r + c) % 2;
            // odd positions swap the products instead of negating
            localparam int IA  = (ODD != 0) ? R0 * 3 + C1 : R0 * 3 + C0;
            localparam int IB  = (ODD != 0) ? R1 * 3 + C0 : R1 * 3 + C1;
            localparam int JA  = (ODD != 0) ? R0 * 3 + C0 : R0 * 3 + C1;
            localparam int JB  = (ODD != 0) ? R1 * 3 + C1 : R1 * 3 + C0;
            assign pa_next[r * 3 + c] = m_in[IA] * m_in[IB];
            assign pb_next[r * 3 + c] = m_in[JA] * m_in[JB];
        end
    end

    // stage 2: cofactors
    logic signed [COF_W-1:0] cof2_reg [N_ENT];
    mat_t                    m2_reg;

    // stage 3: row 0 entries times cofactor slices
    logic signed [PH_W-1:0]  ph3_reg [3];
    logic signed [PH_W-1:0]  pl3_reg [3];
    logic signed [COF_W-1:0] cof3_reg [N_ENT];
    mat_t                    m3_reg;
    ent_t                    row0 [3];
    logic signed [PH_W-1:0]  ph_next [3];
    logic signed [PH_W-1:0]  pl_next [3];

    assign row0[0] = m2_reg.a00;
    assign row0[1] = m2_reg.a01;
    assign row0[2] = m2_reg.a02;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ph_next[c] = row0[c] * $signed(cof2_reg[c][COF_W-1:QUO_W]);
            pl_next[c] = row0[c] * $signed({1'b0, cof2_reg[c][QUO_W-1:0]});
        end
    end

    // stage 4: recombine slices; stage 5: determinant
    logic signed [DET_W-1:0] t4_reg [3];
    logic signed [COF_W-1:0] cof4_reg [N_ENT];
    mat_t                    m4_reg;
    logic signed [DET_W-1:0] det5_reg;
    logic signed [COF_W-1:0] cof5_reg [N_ENT];
    mat_t                    m5_reg;

    // stage 6: magnitudes and signs, lanes in output order
    logic [DM_W-1:0]         detmag6_reg;
    logic                    det_neg6_reg;
    logic                    sing6_reg;
    logic [CMAG_W-1:0]       cmag6_reg [N_ENT];
    logic                    neg6_reg [N_ENT];
    mat_t                    m6_reg;
    logic                    det_neg;
    logic [DET_W-1:0]        det_abs;
    logic [COF_W-1:0]        cof_abs [N_ENT];
    logic                    cof_neg [N_ENT];

    always_comb
    begin
        det_neg = det5_reg[DET_W-1];
        det_abs = det_neg ? DET_W'(-det5_reg) : DET_W'(det5_reg);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // inverse entry (i, j) takes cofactor (j, i)
                cof_neg[i * 3 + j] = cof5_reg[j * 3 + i][COF_W-1];
                cof_abs[i * 3 + j] = cof_neg[i * 3 + j] ? COF_W'(-cof5_reg[j * 3 + i])
                                                        : COF_W'(cof5_reg[j * 3 + i]);
            end
        end
    end

    // divider stages; stage 0 holds the overflow check
    div_t              dq_reg   [DIV_STEPS+1][N_ENT];
    div_t              dq_next  [DIV_STEPS+1][N_ENT];
    logic [DM_W-1:0]   detd_reg [DIV_STEPS+1];
    logic              sd_reg   [DIV_STEPS+1];
    mat_t              md_reg   [DIV_STEPS+1];

    logic [NUM_W-1:0]  num [N_ENT];
    logic [DM_W-1:0]   num_hi [N_ENT];
    logic [DM_W:0]     trial [DIV_STEPS][N_ENT];
    logic [DM_W+1:0]   diff  [DIV_STEPS][N_ENT];

    always_comb
    begin
        // load: numerator is cofactor shifted by twice the fraction width
        for (int k = 0; k < N_ENT; k++)
        begin
            num[k]            = {cmag6_reg[k], {(2 * FRAC_BITS){1'b0}}};
            num_hi[k]         = DM_W'(num[k][NUM_W-1:QUO_W]);
            dq_next[0][k].rem = num_hi[k];
            dq_next[0][k].lo  = num[k][QUO_W-1:0];
            dq_next[0][k].q   = '0;
            dq_next[0][k].neg = neg6_reg[k] ^ det_neg6_reg;
            dq_next[0][k].ovf = (num_hi[k] >= detmag6_reg);
        end
        // one quotient bit per stage
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            for (int k = 0; k < N_ENT; k++)
            begin
                trial[s][k] = {dq_reg[s][k].rem, dq_reg[s][k].lo[QUO_W-1]};
                diff[s][k]  = {1'b0, trial[s][k]} - {2'b00, detd_reg[s]};
                dq_next[s+1][k].rem = diff[s][k][DM_W+1] ? trial[s][k][DM_W-1:0]
                                                         : diff[s][k][DM_W-1:0];
                dq_next[s+1][k].lo  = {dq_reg[s][k].lo[QUO_W-2:0], 1'b0};
                dq_next[s+1][k].q   = {dq_reg[s][k].q[QUO_W-2:0], !diff[s][k][DM_W+1]};
                dq_next[s+1][k].neg = dq_reg[s][k].neg;
                dq_next[s+1][k].ovf = dq_reg[s][k].ovf;
            end
        end
    end

    // output formatting: clamp and apply sign
    logic [QUO_W-1:0] limit [N_ENT];
    logic [QUO_W-1:0] mag   [N_ENT];
    logic             sat_k [N_ENT];
    ent_t             r_val [N_ENT];
    logic             sat_any;
    inv_t             out_next;
    inv_t             out_reg;
    div_t             fin   [N_ENT];
    mat_t             mf;

    always_comb
    begin
        sat_any = 1'b0;
        mf      = md_reg[DIV_STEPS];
        for (int k = 0; k < N_ENT; k++)
        begin
            fin[k]   = dq_reg[DIV_STEPS][k];
            limit[k] = fin[k].neg ? NEG_LIMIT : POS_LIMIT;
            sat_k[k] = fin[k].ovf || (fin[k].q > limit[k]);
            mag[k]   = sat_k[k] ? limit[k] : fin[k].q;
            r_val[k] = fin[k].neg ? ENT_W'(-mag[k]) : ENT_W'(mag[k]);
            sat_any  = sat_any | sat_k[k];
        end
        if (sd_reg[DIV_STEPS])
        begin
            out_next.r00       = mf.a00;
            out_next.r01       = mf.a01;
            out_next.r02       = mf.a02;
            out_next.r10       = mf.a10;
            out_next.r11       = mf.a11;
            out_next.r12       = mf.a12;
            out_next.r20       = mf.a20;
            out_next.r21       = mf.a21;
            out_next.r22       = mf.a22;
            out_next.singular  = 1'b1;
            out_next.saturated = 1'b0;
        end
        else
        begin
            out_next.r00       = r_val[0];
            out_next.r01       = r_val[1];
            out_next.r02       = r_val[2];
            out_next.r10       = r_val[3];
            out_next.r11       = r_val[4];
            out_next.r12       = r_val[5];
            out_next.r20       = r_val[6];
            out_next.r21       = r_val[7];
            out_next.r22       = r_val[8];
            out_next.singular  = 1'b0;
            out_next.saturated = sat_any;
        end
    end

    // payload registers, all moving on the common enable
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            pa1_reg <= pa_next;
            pb1_reg <= pb_next;
            m1_reg  <= mat.data;
            // stage 2
            for (int k = 0; k < N_ENT; k++)
            begin
                cof2_reg[k] <= COF_W'(pa1_reg[k]) - COF_W'(pb1_reg[k]);
            end
            m2_reg <= m1_reg;
            // stage 3
            ph3_reg  <= ph_next;
            pl3_reg  <= pl_next;
            cof3_reg <= cof2_reg;
            m3_reg   <= m2_reg;
            // stage 4
            for (int c = 0; c < 3; c++)
            begin
                t4_reg[c] <= (DET_W'(ph3_reg[c]) <<< QUO_W) + DET_W'(pl3_reg[c]);
            end
            cof4_reg <= cof3_reg;
            m4_reg   <= m3_reg;
            // stage 5
            det5_reg <= t4_reg[0] + t4_reg[1] + t4_reg[2];
            cof5_reg <= cof4_reg;
            m5_reg   <= m4_reg;
            // stage 6
            detmag6_reg  <= det_abs[DM_W-1:0];
            det_neg6_reg <= det_neg;
            sing6_reg    <= (det5_reg == '0);
            for (int k = 0; k < N_ENT; k++)
            begin
                cmag6_reg[k] <= cof_abs[k][CMAG_W-1:0];
                neg6_reg[k]  <= cof_neg[k];
            end
            m6_reg <= m5_reg;
            // divider
            dq_reg[0]   <= dq_next[0];
            detd_reg[0] <= detmag6_reg;
            sd_reg[0]   <= sing6_reg;
            md_reg[0]   <= m6_reg;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                dq_reg[s+1]   <= dq_next[s+1];
                detd_reg[s+1] <= detd_reg[s];
                sd_reg[s+1]   <= sd_reg[s];
                md_reg[s+1]   <= md_reg[s];
            end
            // output
            out_reg <= out_next;
        end
    end

    assign inv.valid = out_valid_reg;
    assign inv.data  = out_reg;

`ifndef NO_ASSERTIONS
    // a singular result never reports saturation
    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        inv.valid && inv.data.singular |-> !inv.data.saturated)
        else $error("singular result with saturated set");

    // lane 0 remainder is below the divisor after the last divide step
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vd_reg[DIV_STEPS] && !sd_reg[DIV_STEPS] && !dq_reg[DIV_STEPS][0].ovf
        |-> dq_reg[DIV_STEPS][0].rem < detd_reg[DIV_STEPS])
        else $error("divider remainder out of range");

    // a valid item at the end of stage 6 enters the divider on the next move
    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        en && vs_reg[5] |=> vd_reg[0])
        else $error("valid bit lost between cofactor and divider stages");
`endif

endmodule

@@ tb/matrix_inverse_3x3_unit_test.sv @@
`timescale 1ns / 100ps

module matrix_inverse_3x3_unit_test;
    import mi3_pkg::*;

    localparam int N_RANDOM   = 725;
    localparam int QUIET_TAIL = 100;   // last random items run with no idling
    localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
    localparam int DRAIN_WAIT = 60;    // extra wait after the scoreboard empties

    logic clk;
    logic rst_n;

    mi3_stream_if #(.T(mat_t)) mat_ch ();
    mi3_stream_if #(.T(inv_t)) inv_ch ();

    matrix_inverse_3x3_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat_ch.sink),
        .inv   (inv_ch.source)
    );

    // Expected inverses in acceptance order, checked against each output transaction
    class inverse_scoreboard;
        inv_t pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        // Signed 2x2 cofactor of the entry at (row, col)
        static function logic signed [127:0] cofactor(logic signed [127:0] a[9],
                                                      int row, int col);
            int r0, r1, c0, c1;
            logic signed [127:0] v;
            r0 = (row == 0) ? 1 : 0;
            r1 = (row == 2) ? 1 : 2;
            c0 = (col == 0) ? 1 : 0;
            c1 = (col == 2) ? 1 : 2;
            v = a[r0*3+c0] * a[r1*3+c1] - a[r0*3+c1] * a[r1*3+c0];
            return ((row + col) % 2 == 1) ? -v : v;
        endfunction

        // Exact adjugate over determinant, truncated and clamped to 32 bits
        static function inv_t inverse_of(mat_t m);
            ent_t e[9];
            ent_t res[9];
            logic signed [127:0] a[9];
            logic signed [127:0] det, c;
            logic [127:0] cm, dm, q, lim;
            logic neg, sat;
            e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
            for (int k = 0; k < 9; k++)
                a[k] = e[k];
            det = a[0]*a[4]*a[8] + a[2]*a[3]*a[7] + a[6]*a[1]*a[5]
                - a[6]*a[4]*a[2] - a[0]*a[5]*a[7] - a[8]*a[1]*a[3];
            if (det == 0)
                return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], 1'b1, 1'b0};
            sat = 1'b0;
            dm = (det < 0) ? -det : det;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    c = cofactor(a, j, i);
                    neg = (c < 0) != (det < 0);
                    cm = (c < 0) ? -c : c;
                    q = (cm << (2 * FRAC_BITS_DEF)) / dm;
                    if (q == 0)
                        neg = 1'b0;
                    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                    if (q > lim)
                    begin
                        q = lim;
                        sat = 1'b1;
                    end
                    res[i*3+j] = neg ? -q[31:0] : q[31:0];
                end
            return {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7],
                    res[8], 1'b0, sat};
        endfunction

        function void note_matrix(mat_t m);
            pending.push_back(inverse_of(m));
        endfunction

        function void check_result(inv_t got);
            inv_t want;
            logic [289:0] gb, wb;
            if (pending.size() == 0)
            begin
                report("output transaction with no matrix outstanding");
                return;
            end
            want = pending.pop_front();
            gb = got;
            wb = want;
            for (int k = 0; k < 9; k++)
                if (gb[289-32*k -: 32] !== wb[289-32*k -: 32])
                    report($sformatf("r%0d%0d got %h want %h", k / 3, k % 3,
                                     gb[289-32*k -: 32], wb[289-32*k -: 32]));
            if (got.singular !== want.singular)
                report($sformatf("singular got %b want %b", got.singular, want.singular));
            if (got.saturated !== want.saturated)
                report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
        endfunction
    endclass

    inverse_scoreboard sb = new();
    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;

    // Clock and reset
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("matrix_inverse_3x3_unit_test: done, errors");
        $finish;
    end

    // Monitor both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mat_ch.valid && mat_ch.ready)
                sb.note_matrix(mat_ch.data);
            if (inv_ch.valid && inv_ch.ready)
                sb.check_result(inv_ch.data);
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        inv_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                inv_ch.ready <= 1'b0;
                hold_req = 1'b0;
                n = 0;
                while (n < HOLD_LEN)
                begin
                    @(posedge clk);
                    n++;
                end
                inv_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                inv_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                inv_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one matrix and wait for the transaction, optionally with a gap first
    task automatic send_matrix(mat_t m);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            mat_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        mat_ch.valid <= 1'b1;
        mat_ch.data  <= m;
        do @(posedge clk); while (!mat_ch.ready);
    endtask

    function automatic ent_t small_entry();
        return ent_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic mat_t make_mat(ent_t e[9]);
        return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    // Full-range and small-entry (within +-4.0) matrices, some built to be singular
    function automatic mat_t random_matrix();
        ent_t e[9];
        int kind, src, dst;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
            e[k] = (kind < 4) ? ent_t'($urandom) : small_entry();
        if (kind == 8)
        begin
            // one row a copy (or negation) of another
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            for (int c = 0; c < 3; c++)
                e[dst*3+c] = $urandom_range(0, 1) ? e[src*3+c] : -e[src*3+c];
        end
        else if (kind == 9)
        begin
            // zero column
            src = $urandom_range(0, 2);
            for (int r = 0; r < 3; r++)
                e[r*3+src] = '0;
        end
        return make_mat(e);
    endfunction

    initial
    begin
        mat_t directed[$];
        localparam ent_t ONE  = 32'sh0001_0000;
        localparam ent_t MAXE = 32'sh7FFF_FFFF;
        localparam ent_t MINE = 32'sh8000_0000;

        mat_ch.valid <= 1'b0;
        mat_ch.data  <= '0;

        // Identity, scaled identity, zero, extremes, exact negative limit
        directed.push_back(make_mat('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}));
        directed.push_back(make_mat('{2*ONE, 0, 0, 0, -ONE/2, 0, 0, 0, 4*ONE}));
        directed.push_back(make_mat('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        directed.push_back(make_mat('{MAXE, MAXE, MAXE, MAXE, MAXE, MAXE, MAXE, MAXE, MAXE}));
        directed.push_back(make_mat('{MINE, MINE, MINE, MINE, MINE, MINE, MINE, MINE, MINE}));
        directed.push_back(make_mat('{MINE, 0, 0, 0, MAXE, 0, 0, 0, MINE}));
        directed.push_back(make_mat('{MAXE, MINE, 0, 0, MAXE, MINE, MINE, 0, MAXE}));
        directed.push_back(make_mat('{-2, 0, 0, 0, ONE, 0, 0, 0, ONE}));
        directed.push_back(make_mat('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
        directed.push_back(make_mat('{-1, 0, 0, 0, -1, 0, 0, 0, -1}));
        directed.push_back(make_mat('{0, ONE, 0, ONE, 0, 0, 0, 0, ONE}));
        directed.push_back(make_mat('{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE,
                                      7*ONE, 8*ONE, 9*ONE}));
        directed.push_back(make_mat('{ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE,
                                      5*ONE, 6*ONE, 0}));
        directed.push_back(make_mat('{3*ONE, 0, 0, 0, 3*ONE, 0, 0, 0, 3*ONE}));
        directed.push_back(make_mat('{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE}));
        directed.push_back(make_mat('{32'sh5555_5555, 32'shAAAA_AAAA, 1, -1,
                                      32'sh0F0F_0F0F, 32'shF0F0_F0F0, 3, 5, 7}));

        while (!rst_n) @(posedge clk);
        @(posedge clk);

        foreach (directed[i])
            send_matrix(directed[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 250)
                hold_req = 1'b1;   // sender keeps offering while results back up
            if (n == 450)
            begin
                // let everything drain before going on
                mat_ch.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending.size() != 0) @(posedge clk);
            end
            if (n == N_RANDOM - QUIET_TAIL)
                idle_on = 1'b0;
            send_matrix(random_matrix());
        end
        mat_ch.valid <= 1'b0;

        // Drain, then wait out DRAIN_WAIT for anything stray
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
            $display("matrix_inverse_3x3_unit_test: done, clean");
        else
            $display("matrix_inverse_3x3_unit_test: done, errors");
        $finish;
    end

endmodule
